>>> sv/cosp_pkg.sv
`default_nettype none

package cosp_pkg;

  // Fixed field and datapath widths
  localparam int RATING_W = 16;
  localparam int NORM_W   = 16;
  localparam int COS_W    = 16;
  localparam int MUL_W    = 24;               // one operand of the shared multiplier
  localparam int PP_W     = 2 * MUL_W;        // multiplier product width
  localparam int ACC_W    = 48;               // dot product and sums of squares
  localparam int PROD_W   = 2 * ACC_W;        // product of the two sums of squares
  localparam int ROOT_W   = PROD_W / 2;       // floor root of that product
  localparam int SUB_W    = ROOT_W + 4;       // shared subtractor / remainder width
  localparam int Q_W      = 16;               // quotient bits produced by the divide
  localparam int FRAC_W   = 14;               // Q2.14 fraction bits
  localparam int STEP_W   = $clog2(ROOT_W);   // iteration counter

  localparam logic [Q_W-1:0] COS_ONE = Q_W'(1 << FRAC_W);

  localparam int DEF_MAX_ITEMS = 4096;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_MIN_NORM_SQ = 1'b0;    // word index of min_norm_sq

  typedef enum logic [2:0] {
    TAG_DOT,
    TAG_SQ_A,
    TAG_SQ_B,
    TAG_PP_LO,
    TAG_PP_MID,
    TAG_PP_HI
  } mul_tag_t;

  typedef struct packed {
    logic             valid;
    mul_tag_t         tag;
    logic             neg;
    logic [MUL_W-1:0] op_a;
    logic [MUL_W-1:0] op_b;
  } mul_req_t;

  typedef struct packed {
    logic            valid;
    mul_tag_t        tag;
    logic            neg;
    logic [PP_W-1:0] prod;
  } mul_rsp_t;

endpackage

`default_nettype wire

>>> sv/cosine_similarity_pair.sv
`default_nettype none

// Cosine similarity of two signed Q8.8 vectors that arrive one element pair per
// input transaction; in_last marks the final pair. Each pair takes the
// accept state, three passes through the single shared 24x24 multiplier
// (a*b, a*a, b*b) and a state that retires the last product into the
// accumulators. A pair past MAX_ITEMS skips the multiplier and only sets the
// too_long flag. The last pair then adds the zero-vector check against
// min_norm_sq, four multiplier passes plus a wait for the 96-bit product of the
// two sums of squares, a bit-per-cycle square root over 48 root bits and a
// 16-bit restoring divide (both on one shared 52-bit subtractor), and the
// hand-off of the result to the output register.
// A zero vector skips the root and divide. The result is
// cosine = trunc(dot * 16384 / floor(sqrt(sumsq_a * sumsq_b))) in Q2.14, clamped
// to +/-16384; zero_norm forces it to 0. The output register holds a result
// until taken while the next vector's pairs are accepted; a new result waits
// for the register to free up. min_norm_sq lives at byte address 0 (reset 0)
// and must be written only while the block is idle.

module cosine_similarity_pair import cosp_pkg::*; #(
  parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Input channel
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [RATING_W-1:0] in_rating_a,
  input  wire logic signed [RATING_W-1:0] in_rating_b,
  input  wire logic                       in_last,
  // Result channel
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [COS_W-1:0]         out_cosine,
  output logic                            out_zero_norm,
  output logic                            out_too_long,
  // Configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [CFG_AW-1:0]          paddr,
  input  wire logic [CFG_DW-1:0]          pwdata,
  output logic [CFG_DW-1:0]               prdata,
  output logic                            pready
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DOT,
    S_SQ_A,
    S_SQ_B,
    S_ACC,
    S_CHECK,
    S_PROD,
    S_PWAIT,
    S_SQRT,
    S_DIV,
    S_DONE
  } state_t;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [NORM_W-1:0] min_norm_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_norm_sq_r <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MIN_NORM_SQ) begin
      min_norm_sq_r <= pwdata[NORM_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MIN_NORM_SQ) ? CFG_DW'(min_norm_sq_r) : '0;

  // ---------------------------------------------------------------------------
  // Shared multiplier
  // ---------------------------------------------------------------------------
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  cosp_mul_unit u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .rsp  (mul_rsp)
  );

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_t                    state_r,      state_nxt;
  logic [MUL_W-1:0]          mag_a_r,      mag_a_nxt;
  logic [MUL_W-1:0]          mag_b_r,      mag_b_nxt;
  logic                      pair_neg_r,   pair_neg_nxt;
  logic                      last_r,       last_nxt;
  logic [CNT_W-1:0]          pair_cnt_r,   pair_cnt_nxt;
  logic                      overflow_r,   overflow_nxt;
  logic signed [ACC_W-1:0]   dot_acc_r,    dot_acc_nxt;
  logic [ACC_W-1:0]          sumsq_a_r,    sumsq_a_nxt;
  logic [ACC_W-1:0]          sumsq_b_r,    sumsq_b_nxt;
  logic [PROD_W-1:0]         prod_r,       prod_nxt;
  logic [ROOT_W-1:0]         root_r,       root_nxt;
  logic [SUB_W-1:0]          rem_r,        rem_nxt;
  logic [Q_W-1:0]            nlow_r,       nlow_nxt;
  logic [Q_W-1:0]            quo_r,        quo_nxt;
  logic [STEP_W-1:0]         step_r,       step_nxt;
  logic                      zero_r,       zero_nxt;
  logic                      out_valid_r,  out_valid_nxt;
  logic signed [COS_W-1:0]   out_cos_r,    out_cos_nxt;
  logic                      out_zero_r,   out_zero_nxt;
  logic                      out_long_r,   out_long_nxt;

  // Shared subtractor for root and divide
  logic [SUB_W-1:0]  sub_a;
  logic [SUB_W-1:0]  sub_b;
  logic [SUB_W:0]    sub_diff;
  logic              sub_ge;

  // Helpers
  logic [RATING_W:0]  abs_a;
  logic [RATING_W:0]  abs_b;
  logic [ACC_W-1:0]   dot_mag;
  logic [Q_W-1:0]     quo_clamped;
  logic [ACC_W-1:0]   min_norm_ext;
  logic               in_accept;
  logic               out_free;

  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = ~sub_diff[SUB_W];

  assign in_accept    = in_valid && !in_stall;
  assign out_free     = !out_valid_r || !out_stall;
  assign min_norm_ext = ACC_W'(min_norm_sq_r);

  always_comb begin
    abs_a       = in_rating_a[RATING_W-1] ? -{in_rating_a[RATING_W-1], in_rating_a}
                                          :  {in_rating_a[RATING_W-1], in_rating_a};
    abs_b       = in_rating_b[RATING_W-1] ? -{in_rating_b[RATING_W-1], in_rating_b}
                                          :  {in_rating_b[RATING_W-1], in_rating_b};
    dot_mag     = dot_acc_r[ACC_W-1] ? ACC_W'(-dot_acc_r) : ACC_W'(dot_acc_r);
    quo_clamped = (quo_r > COS_ONE) ? COS_ONE : quo_r;
  end

  always_comb begin
    state_nxt     = state_r;
    mag_a_nxt     = mag_a_r;
    mag_b_nxt     = mag_b_r;
    pair_neg_nxt  = pair_neg_r;
    last_nxt      = last_r;
    pair_cnt_nxt  = pair_cnt_r;
    overflow_nxt  = overflow_r;
    dot_acc_nxt   = dot_acc_r;
    sumsq_a_nxt   = sumsq_a_r;
    sumsq_b_nxt   = sumsq_b_r;
    prod_nxt      = prod_r;
    root_nxt      = root_r;
    rem_nxt       = rem_r;
    nlow_nxt      = nlow_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_cos_nxt   = out_cos_r;
    out_zero_nxt  = out_zero_r;
    out_long_nxt  = out_long_r;

    mul_req.valid = 1'b0;
    mul_req.tag   = TAG_DOT;
    mul_req.neg   = 1'b0;
    mul_req.op_a  = mag_a_r;
    mul_req.op_b  = mag_b_r;

    sub_a = {rem_r[SUB_W-3:0], prod_r[PROD_W-1 -: 2]};
    sub_b = {2'b00, root_r, 2'b01};

    // Retire multiplier products into the accumulators
    if (mul_rsp.valid) begin
      case (mul_rsp.tag)
        TAG_DOT: begin
          if (mul_rsp.neg) begin
            dot_acc_nxt = dot_acc_r - $signed(ACC_W'(mul_rsp.prod));
          end else begin
            dot_acc_nxt = dot_acc_r + $signed(ACC_W'(mul_rsp.prod));
          end
        end
        TAG_SQ_A:   sumsq_a_nxt = sumsq_a_r + ACC_W'(mul_rsp.prod);
        TAG_SQ_B:   sumsq_b_nxt = sumsq_b_r + ACC_W'(mul_rsp.prod);
        TAG_PP_LO:  prod_nxt = prod_r + PROD_W'(mul_rsp.prod);
        TAG_PP_MID: prod_nxt = prod_r + (PROD_W'(mul_rsp.prod) << MUL_W);
        TAG_PP_HI:  prod_nxt = prod_r + (PROD_W'(mul_rsp.prod) << (2 * MUL_W));
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          mag_a_nxt    = MUL_W'(abs_a);
          mag_b_nxt    = MUL_W'(abs_b);
          pair_neg_nxt = in_rating_a[RATING_W-1] ^ in_rating_b[RATING_W-1];
          last_nxt     = in_last;
          if (pair_cnt_r < CNT_W'(MAX_ITEMS)) begin
            pair_cnt_nxt = pair_cnt_r + 1'b1;
            state_nxt    = S_DOT;
          end else begin
            // Drop the pair, remember the overflow
            overflow_nxt = 1'b1;
            state_nxt    = in_last ? S_CHECK : S_IDLE;
          end
        end
      end
      S_DOT: begin
        mul_req.valid = 1'b1;
        mul_req.tag   = TAG_DOT;
        mul_req.neg   = pair_neg_r;
        state_nxt     = S_SQ_A;
      end
      S_SQ_A: begin
        mul_req.valid = 1'b1;
        mul_req.tag   = TAG_SQ_A;
        mul_req.op_b  = mag_a_r;
        state_nxt     = S_SQ_B;
      end
      S_SQ_B: begin
        mul_req.valid = 1'b1;
        mul_req.tag   = TAG_SQ_B;
        mul_req.op_a  = mag_b_r;
        state_nxt     = S_ACC;
      end
      S_ACC: begin
        state_nxt = last_r ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        if (sumsq_a_r <= min_norm_ext || sumsq_b_r <= min_norm_ext) begin
          zero_nxt  = 1'b1;
          quo_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          prod_nxt  = '0;
          step_nxt  = '0;
          state_nxt = S_PROD;
        end
      end
      S_PROD: begin
        // Four 24x24 partial products of sumsq_a * sumsq_b
        mul_req.valid = 1'b1;
        case (step_r[1:0])
          2'd0: begin
            mul_req.tag  = TAG_PP_LO;
            mul_req.op_a = sumsq_a_r[MUL_W-1:0];
            mul_req.op_b = sumsq_b_r[MUL_W-1:0];
          end
          2'd1: begin
            mul_req.tag  = TAG_PP_MID;
            mul_req.op_a = sumsq_a_r[MUL_W-1:0];
            mul_req.op_b = sumsq_b_r[ACC_W-1:MUL_W];
          end
          2'd2: begin
            mul_req.tag  = TAG_PP_MID;
            mul_req.op_a = sumsq_a_r[ACC_W-1:MUL_W];
            mul_req.op_b = sumsq_b_r[MUL_W-1:0];
          end
          default: begin
            mul_req.tag  = TAG_PP_HI;
            mul_req.op_a = sumsq_a_r[ACC_W-1:MUL_W];
            mul_req.op_b = sumsq_b_r[ACC_W-1:MUL_W];
          end
        endcase
        step_nxt = step_r + 1'b1;
        if (step_r[1:0] == 2'd3) begin
          state_nxt = S_PWAIT;
        end
      end
      S_PWAIT: begin
        // Last partial product lands this cycle
        step_nxt  = '0;
        root_nxt  = '0;
        rem_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        // One root bit per cycle: bring down two product bits, try (root<<2)|1
        prod_nxt = prod_r << 2;
        if (sub_ge) begin
          rem_nxt  = sub_diff[SUB_W-1:0];
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = sub_a;
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(ROOT_W - 1)) begin
          // Set up (|dot| << 14) / root; upper part is already below the divisor
          step_nxt  = '0;
          rem_nxt   = SUB_W'(dot_mag >> 2);
          nlow_nxt  = {dot_mag[1:0], {FRAC_W{1'b0}}};
          quo_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        sub_a    = {rem_r[SUB_W-2:0], nlow_r[Q_W-1]};
        sub_b    = SUB_W'(root_r);
        nlow_nxt = nlow_r << 1;
        if (sub_ge) begin
          rem_nxt = sub_diff[SUB_W-1:0];
        end else begin
          rem_nxt = sub_a;
        end
        quo_nxt  = {quo_r[Q_W-2:0], sub_ge};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(Q_W - 1)) begin
          zero_nxt  = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cos_nxt   = dot_acc_r[ACC_W-1] ? -$signed(quo_clamped) : $signed(quo_clamped);
          out_zero_nxt  = zero_r;
          out_long_nxt  = overflow_r;
          // Clear the accumulators for the next vector pair
          dot_acc_nxt   = '0;
          sumsq_a_nxt   = '0;
          sumsq_b_nxt   = '0;
          pair_cnt_nxt  = '0;
          overflow_nxt  = 1'b0;
          zero_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pair_cnt_r  <= '0;
      overflow_r  <= 1'b0;
      dot_acc_r   <= '0;
      sumsq_a_r   <= '0;
      sumsq_b_r   <= '0;
      step_r      <= '0;
      zero_r      <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pair_cnt_r  <= pair_cnt_nxt;
      overflow_r  <= overflow_nxt;
      dot_acc_r   <= dot_acc_nxt;
      sumsq_a_r   <= sumsq_a_nxt;
      sumsq_b_r   <= sumsq_b_nxt;
      step_r      <= step_nxt;
      zero_r      <= zero_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_a_r    <= mag_a_nxt;
    mag_b_r    <= mag_b_nxt;
    pair_neg_r <= pair_neg_nxt;
    prod_r     <= prod_nxt;
    root_r     <= root_nxt;
    rem_r      <= rem_nxt;
    nlow_r     <= nlow_nxt;
    quo_r      <= quo_nxt;
    out_cos_r  <= out_cos_nxt;
    out_zero_r <= out_zero_nxt;
    out_long_r <= out_long_nxt;
  end

  // Take a pair only while the sequencer waits for one
  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_cosine    = out_cos_r;
  assign out_zero_norm = out_zero_r;
  assign out_too_long  = out_long_r;

endmodule

`default_nettype wire

>>> sv/cosp_mul_unit.sv
`default_nettype none

module cosp_mul_unit import cosp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mul_req_t req,
  output mul_rsp_t      rsp
);

  mul_rsp_t rsp_r;
  mul_rsp_t rsp_nxt;

  always_comb begin
    rsp_nxt.valid = req.valid;
    rsp_nxt.tag   = req.tag;
    rsp_nxt.neg   = req.neg;
    rsp_nxt.prod  = PP_W'(req.op_a) * PP_W'(req.op_b);
  end

  // Register the product; tag and sign travel along with it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_r.valid <= 1'b0;
      rsp_r.tag   <= TAG_DOT;
      rsp_r.neg   <= 1'b0;
    end else begin
      rsp_r.valid <= rsp_nxt.valid;
      rsp_r.tag   <= rsp_nxt.tag;
      rsp_r.neg   <= rsp_nxt.neg;
    end
    rsp_r.prod <= rsp_nxt.prod;
  end

  assign rsp = rsp_r;

endmodule

`default_nettype wire

>>> tb/cosine_similarity_pair_tb.sv
`timescale 1ns / 1ps

module cosine_similarity_pair_tb;
  import cosp_pkg::*;

  localparam int MAX_ITEMS   = DEF_MAX_ITEMS;
  localparam int SETTLE      = 120;      // idle wait after the last owed result arrives
  localparam int HOLD_CYCLES = 600;      // long receiver hold-off
  localparam int LIMIT       = 1000000;  // watchdog limit on the run

  typedef struct packed {
    logic signed [COS_W-1:0] cosine;
    logic                    zero_norm;
    logic                    too_long;
  } cos_result_t;

  // Tracks the accumulators the block should hold and the results it owes.
  class cosine_ledger;
    logic [NORM_W-1:0]  min_norm;
    logic signed [47:0] dot_sum;
    logic [47:0]        sq_a_sum;
    logic [47:0]        sq_b_sum;
    int unsigned        pair_count;
    bit                 overflowed;
    cos_result_t        owed_q[$];
    int                 errors;

    function new();
      min_norm = '0;
      errors   = 0;
      clear_vector();
    endfunction

    function void clear_vector();
      dot_sum    = '0;
      sq_a_sum   = '0;
      sq_b_sum   = '0;
      pair_count = 0;
      overflowed = 1'b0;
    endfunction

    function void set_min_norm(logic [NORM_W-1:0] v);
      min_norm = v;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Accumulate one accepted pair; on the last pair work out the cosine.
    function void note_pair(logic signed [RATING_W-1:0] a, logic signed [RATING_W-1:0] b,
                            logic last_pair);
      logic signed [31:0] ab;
      logic signed [31:0] aa;
      logic signed [31:0] bb;
      logic [95:0]        norm_prod;
      logic [97:0]        root;
      logic [97:0]        cand;
      logic [63:0]        mag;
      logic [63:0]        den;
      logic [63:0]        quo;
      logic               neg;
      cos_result_t        r;
      ab = a * b;
      aa = a * a;
      bb = b * b;
      if (pair_count < MAX_ITEMS) begin
        dot_sum    = dot_sum + 48'(ab);
        sq_a_sum   = sq_a_sum + {16'b0, aa};
        sq_b_sum   = sq_b_sum + {16'b0, bb};
        pair_count = pair_count + 1;
      end else begin
        overflowed = 1'b1;
      end
      if (!last_pair) return;
      r.cosine    = '0;
      r.zero_norm = 1'b0;
      r.too_long  = overflowed;
      if (sq_a_sum <= 48'(min_norm) || sq_b_sum <= 48'(min_norm)) begin
        r.zero_norm = 1'b1;
      end else begin
        norm_prod = 96'(sq_a_sum) * 96'(sq_b_sum);
        root = '0;
        for (int i = 48; i >= 0; i--) begin
          cand = root | (98'd1 << i);
          if (cand * cand <= 98'(norm_prod)) root = cand;
        end
        neg = dot_sum[47];
        mag = neg ? 64'(-dot_sum) : 64'(dot_sum);
        den = (root == 0) ? 64'd1 : root[63:0];
        quo = (mag << FRAC_W) / den;
        if (quo > 64'(COS_ONE)) quo = 64'(COS_ONE);
        r.cosine = neg ? -quo[COS_W-1:0] : quo[COS_W-1:0];
      end
      owed_q.push_back(r);
      clear_vector();
    endfunction

    function void check_result(logic signed [COS_W-1:0] cosine, logic zero_norm,
                               logic too_long);
      cos_result_t want;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: cosine %0d zero_norm %0b too_long %0b",
                 $time, cosine, zero_norm, too_long);
        return;
      end
      want = owed_q.pop_front();
      if (cosine !== want.cosine) begin
        errors++;
        $display("%0t: cosine mismatch: expected %0d, actual %0d",
                 $time, want.cosine, cosine);
      end
      if (zero_norm !== want.zero_norm) begin
        errors++;
        $display("%0t: zero_norm mismatch: expected %0b, actual %0b",
                 $time, want.zero_norm, zero_norm);
      end
      if (too_long !== want.too_long) begin
        errors++;
        $display("%0t: too_long mismatch: expected %0b, actual %0b",
                 $time, want.too_long, too_long);
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [RATING_W-1:0] in_rating_a = '0;
  logic signed [RATING_W-1:0] in_rating_b = '0;
  logic                       in_last = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [COS_W-1:0]    out_cosine;
  logic                       out_zero_norm;
  logic                       out_too_long;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [CFG_AW-1:0]          paddr = '0;
  logic [CFG_DW-1:0]          pwdata = '0;
  logic [CFG_DW-1:0]          prdata;
  logic                       pready;

  cosine_ledger ledger = new();

  // Shared knobs between the sender and the result sink.
  bit calm     = 1'b0;   // no idling on either side
  bit hold_req = 1'b0;   // ask the sink for one long hold-off
  int gap_odds = 4;      // sender idles with chance 1 in gap_odds, 0 means never
  int gap_left = 0;      // pairs until gap_odds is re-picked
  int cycle_count = 0;

  cosine_similarity_pair dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rating_a   (in_rating_a),
    .in_rating_b   (in_rating_b),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_cosine    (out_cosine),
    .out_zero_norm (out_zero_norm),
    .out_too_long  (out_too_long),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: end the run if the block hangs somewhere.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result monitor: sample at the edge, where stall and valid still hold the
  // values of the cycle that just ended.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      ledger.check_result(out_cosine, out_zero_norm, out_too_long);
  end

  // Result sink: random stall bursts in stretches, quiet stretches in between,
  // and one long hold-off on request so the block backs up into its input.
  initial begin : result_sink
    int burst;
    int hold_count;
    int stall_odds;
    int stretch_left;
    stall_odds   = 5;
    stretch_left = 0;
    wait (rst_n);
    forever begin
      if (stretch_left == 0) begin
        stall_odds   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 15);
        stretch_left = $urandom_range(50, 300);
      end
      stretch_left--;
      if (hold_req) begin
        out_stall <= 1'b1;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        burst = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  // Offer one pair, optionally after an idle burst; return at the accepting edge.
  task automatic send_pair(input logic signed [RATING_W-1:0] a,
                           input logic signed [RATING_W-1:0] b, input logic last_pair);
    int gap;
    if (gap_left == 0) begin
      gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 12);
      gap_left = $urandom_range(20, 150);
    end
    gap_left--;
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_rating_a <= a;
    in_rating_b <= b;
    in_last     <= last_pair;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ledger.note_pair(a, b, last_pair);
  endtask

  // Stop sending and wait for every owed result, then let the block settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Two-phase register write; junk in the upper data bits must be dropped.
  task automatic write_min_norm(input logic [NORM_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(4 * REG_MIN_NORM_SQ);
    pwdata  <= {16'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ledger.set_min_norm(v);
    @(posedge clk);
  endtask

  // Element values: full range, small magnitudes near the threshold, or extremes.
  function automatic logic signed [RATING_W-1:0] pick_rating(input int flavor);
    logic signed [RATING_W-1:0] v;
    case (flavor)
      1: v = RATING_W'($urandom_range(0, 600)) - 16'sd300;
      2: begin
        case ($urandom_range(0, 4))
          0: v = 16'sh8000;
          1: v = 16'sh7FFF;
          2: v = 16'sd0;
          3: v = 16'sd1;
          default: v = -16'sd1;
        endcase
      end
      default: v = RATING_W'($urandom);
    endcase
    return v;
  endfunction

  // Send a vector of len pairs; b tracks a in several ways so cosines spread
  // over the whole range, not just near zero.
  task automatic send_vector(input int len, input int flavor);
    logic signed [RATING_W-1:0] a;
    logic signed [RATING_W-1:0] b;
    int tie;
    tie = $urandom_range(0, 3);
    for (int k = 0; k < len; k++) begin
      a = pick_rating(flavor);
      case (tie)
        1: b = a;
        2: b = -a;
        3: b = a + (RATING_W'($urandom_range(0, 64)) - 16'sd32);
        default: b = pick_rating(flavor);
      endcase
      send_pair(a, b, k == len - 1);
    end
  endtask

  // Mostly short vectors, now and then a longer one.
  task automatic random_vectors(input int pair_budget);
    int sent;
    int len;
    sent = 0;
    while (sent < pair_budget) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      send_vector(len, $urandom_range(0, 2));
      sent += len;
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Threshold at zero: only an all-zero vector counts as zero.
    write_min_norm(16'd0);

    // Extremes, parallel and anti-parallel vectors.
    send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
    send_pair(16'sh8000, 16'sh7FFF, 1'b1);
    send_pair(16'sh8000, 16'sh8000, 1'b1);
    send_pair(16'sd1, 16'sd1, 1'b1);
    send_pair(16'sd1, -16'sd1, 1'b1);
    // Zero vectors on either side and on both.
    send_pair(16'sd0, 16'sd5, 1'b1);
    send_pair(16'sh7FFF, 16'sd0, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd0, 1'b1);
    // Orthogonal pair gives a cosine of zero without the flag.
    send_pair(16'sd256, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd256, 1'b1);
    // Floor root equals the dot product: quotient hits the clamp value.
    send_pair(16'sd1, 16'sd1, 1'b0);
    send_pair(16'sd2, 16'sd3, 1'b1);
    // Mixed signs and extremes.
    send_pair(16'sh8000, -16'sd1, 1'b0);
    send_pair(16'sh7FFF, 16'sd1, 1'b0);
    send_pair(-16'sd1, 16'sh8000, 1'b1);
    drain_results();

    // Highest threshold: sums of squares at 65535 or below count as zero.
    write_min_norm(16'hFFFF);
    send_pair(16'sh0100, 16'sh0100, 1'b1);
    send_pair(16'sh00FF, 16'sh0100, 1'b1);
    send_pair(16'sh00FF, 16'sh00FF, 1'b0);
    send_pair(16'sd1, 16'sd0, 1'b1);
    send_pair(-16'sh0100, 16'sh0100, 1'b1);
    random_vectors(300);
    drain_results();

    // Random threshold; fill the block with a long receiver hold-off.
    write_min_norm(16'($urandom));
    random_vectors(150);
    hold_req = 1'b1;
    for (int n = 0; n < 30; n++) send_vector($urandom_range(1, 2), $urandom_range(0, 2));
    random_vectors(120);
    drain_results();

    // Threshold of one; pause the sender midway until all results are in.
    write_min_norm(16'd1);
    random_vectors(150);
    drain_results();
    random_vectors(150);
    drain_results();

    // Zero threshold again.
    write_min_norm(16'd0);
    random_vectors(300);
    drain_results();

    // Final stretch: mid threshold, no idling anywhere.
    write_min_norm(16'd300);
    calm = 1'b1;
    random_vectors(300);
    drain_results();

    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
